/* hw/rtl/ucfp_pkg.sv */
package ucfp_pkg;

    localparam logic [7:0] MOTOR_START  = 8'hFC;
    localparam logic [7:0] MOTOR_END    = 8'hFD;
    localparam logic [7:0] LIGHT_START  = 8'hFA;
    localparam logic [7:0] LIGHT_TAG    = 8'h4C;
    localparam logic [7:0] LIGHT_END    = 8'hFB;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] SPEED_LIMIT_RESET = 8'd150;

    localparam logic [2:0] MOTOR_LAST_POS = 3'd5;
    localparam logic [2:0] TEXT_LAST_POS  = 3'd4;

    localparam logic [1:0] TAKEN_MOTOR = 2'd0;
    localparam logic [1:0] TAKEN_LIGHT = 2'd1;
    localparam logic [1:0] TAKEN_TEXT  = 2'd2;

    localparam logic [1:0] LIGHT_NONE = 2'd0;
    localparam logic [1:0] LIGHT_OFF  = 2'd1;
    localparam logic [1:0] LIGHT_ON   = 2'd2;

    localparam logic [1:0] TEXT_NONE  = 2'd0;
    localparam logic [1:0] TEXT_HELLO = 2'd1;
    localparam logic [1:0] TEXT_STOP  = 2'd2;

    typedef enum logic [2:0] {
        LIGHT_IDLE,
        LIGHT_GOT_START,
        LIGHT_GOT_TAG,
        LIGHT_GOT_STATE,
        LIGHT_GOT_CHECK
    } light_phase_t;

    function automatic logic [7:0] hello_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h48; // H
            3'd1:    c = 8'h45; // E
            3'd2:    c = 8'h4C; // L
            3'd3:    c = 8'h4C; // L
            3'd4:    c = 8'h4F; // O
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] stop_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h53; // S
            3'd1:    c = 8'h54; // T
            3'd2:    c = 8'h4F; // O
            3'd3:    c = 8'h50; // P
            3'd4:    c = 8'h21; // !
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/uart_command_frame_parser.sv */
// path: an accepted beat goes into the byte register, then its result into the result
//   register, once the result register is free
// throughput: one byte per cycle unless out_ready stalls, set by the single decode
//   pass between the registers; in_ready follows out_ready through the byte register
// reset: rst_n clears parser positions, held commands, speed_limit (to 150) and both
//   valid flags; the motor byte store is written before it is read, so it has no reset
module uart_command_frame_parser
    import ucfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] taken_by,
    output logic       motor_update,
    output logic       left_direction,
    output logic [7:0] left_speed,
    output logic       right_direction,
    output logic [7:0] right_speed,
    output logic       light_update,
    output logic [1:0] light_command,
    output logic       text_update,
    output logic [1:0] text_command
);

    logic [7:0]   speed_limit_reg;
    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    logic         advance;

    logic [2:0]   motor_pos_reg, motor_pos_next;
    logic [7:0]   motor_bytes_reg [4];
    logic [1:0]   motor_idx;
    logic         motor_take, motor_write, motor_hit;

    light_phase_t light_phase_reg, light_phase_next;
    logic         light_value_reg;
    logic         light_take, light_hit, light_store;

    logic [2:0]   text_pos_reg, text_pos_next;
    logic         hello_ok_reg, hello_ok_next;
    logic         stop_ok_reg, stop_ok_next;
    logic         text_hit;
    logic [1:0]   text_cmd_next;

    logic         held_left_dir_reg, held_right_dir_reg;
    logic [7:0]   held_left_speed_reg, held_right_speed_reg;
    logic [1:0]   held_light_reg, held_text_reg;

    logic         out_valid_reg;
    logic [1:0]   taken_by_reg, taken_by_next;
    logic         motor_update_reg, light_update_reg, text_update_reg;

    logic [7:0]   b;

    assign b         = s1_byte_reg;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign motor_idx = 2'(motor_pos_reg - 3'd1);

    // motor parser, highest priority
    always_comb
    begin
        motor_take     = 1'b1;
        motor_write    = 1'b0;
        motor_hit      = 1'b0;
        motor_pos_next = motor_pos_reg;
        if (b == MOTOR_START)
        begin
            motor_pos_next = 3'd1;
        end
        else if (motor_pos_reg == 3'd0)
        begin
            motor_take = 1'b0;
        end
        else if (motor_pos_reg < MOTOR_LAST_POS)
        begin
            motor_write    = 1'b1;
            motor_pos_next = motor_pos_reg + 3'd1;
        end
        else
        begin
            motor_pos_next = 3'd0;
            motor_hit = (b == MOTOR_END)
                && (motor_bytes_reg[0] <= 8'd1) && (motor_bytes_reg[1] <= speed_limit_reg)
                && (motor_bytes_reg[2] <= 8'd1) && (motor_bytes_reg[3] <= speed_limit_reg);
        end
    end

    // light frame next phase
    always_comb
    begin
        light_phase_next = light_phase_reg;
        if (!motor_take)
        begin
            unique case (light_phase_reg)
                LIGHT_IDLE:
                    light_phase_next = (b == LIGHT_START) ? LIGHT_GOT_START : LIGHT_IDLE;
                LIGHT_GOT_START:
                    light_phase_next = (b == LIGHT_TAG)   ? LIGHT_GOT_TAG :
                                       (b == LIGHT_START) ? LIGHT_GOT_START : LIGHT_IDLE;
                LIGHT_GOT_TAG:
                    light_phase_next = (b <= 8'd1)        ? LIGHT_GOT_STATE :
                                       (b == LIGHT_START) ? LIGHT_GOT_START : LIGHT_IDLE;
                LIGHT_GOT_STATE:
                    light_phase_next = (b == (LIGHT_TAG ^ {7'd0, light_value_reg}))
                                       ? LIGHT_GOT_CHECK : LIGHT_IDLE;
                LIGHT_GOT_CHECK:
                    light_phase_next = LIGHT_IDLE;
                default:
                    light_phase_next = LIGHT_IDLE;
            endcase
        end
    end

    // light frame outputs
    always_comb
    begin
        light_take  = 1'b1;
        light_hit   = 1'b0;
        light_store = 1'b0;
        unique case (light_phase_reg)
            LIGHT_IDLE:      light_take  = (b == LIGHT_START);
            LIGHT_GOT_START: light_take  = 1'b1;
            LIGHT_GOT_TAG:   light_store = (b <= 8'd1);
            LIGHT_GOT_STATE: light_take  = 1'b1;
            LIGHT_GOT_CHECK: light_hit   = (b == LIGHT_END);
            default:         light_take  = 1'b0;
        endcase
        if (motor_take)
        begin
            light_take  = 1'b0;
            light_hit   = 1'b0;
            light_store = 1'b0;
        end
    end

    // text matcher keeps running match flags instead of the characters
    always_comb
    begin
        text_pos_next = text_pos_reg;
        hello_ok_next = hello_ok_reg;
        stop_ok_next  = stop_ok_reg;
        text_hit      = 1'b0;
        text_cmd_next = held_text_reg;
        if (!motor_take && !light_take)
        begin
            if (b == CHAR_CR || b == CHAR_LF)
            begin
                text_pos_next = 3'd0;
            end
            else
            begin
                hello_ok_next = ((text_pos_reg == 3'd0) || hello_ok_reg)
                                && (b == hello_char(text_pos_reg));
                stop_ok_next  = ((text_pos_reg == 3'd0) || stop_ok_reg)
                                && (b == stop_char(text_pos_reg));
                if (text_pos_reg >= TEXT_LAST_POS)
                begin
                    text_pos_next = 3'd0;
                    if (hello_ok_next)
                    begin
                        text_hit      = 1'b1;
                        text_cmd_next = TEXT_HELLO;
                    end
                    else if (stop_ok_next)
                    begin
                        text_hit      = 1'b1;
                        text_cmd_next = TEXT_STOP;
                    end
                end
                else
                begin
                    text_pos_next = text_pos_reg + 3'd1;
                end
            end
        end
    end

    always_comb
    begin
        if (motor_take)
            taken_by_next = TAKEN_MOTOR;
        else if (light_take)
            taken_by_next = TAKEN_LIGHT;
        else
            taken_by_next = TAKEN_TEXT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= SPEED_LIMIT_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            motor_pos_reg   <= 3'd0;
            light_phase_reg <= LIGHT_IDLE;
            light_value_reg <= 1'b0;
            text_pos_reg    <= 3'd0;
            hello_ok_reg    <= 1'b0;
            stop_ok_reg     <= 1'b0;
            held_left_dir_reg    <= 1'b0;
            held_left_speed_reg  <= 8'd0;
            held_right_dir_reg   <= 1'b0;
            held_right_speed_reg <= 8'd0;
            held_light_reg  <= LIGHT_NONE;
            held_text_reg   <= TEXT_NONE;
        end
        else
        begin
            if (cfg_write)
                speed_limit_reg <= cfg_data;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                motor_pos_reg   <= motor_pos_next;
                light_phase_reg <= light_phase_next;
                if (light_store)
                    light_value_reg <= b[0];
                text_pos_reg    <= text_pos_next;
                hello_ok_reg    <= hello_ok_next;
                stop_ok_reg     <= stop_ok_next;
                if (motor_hit)
                begin
                    held_left_dir_reg    <= motor_bytes_reg[0][0];
                    held_left_speed_reg  <= motor_bytes_reg[1];
                    held_right_dir_reg   <= motor_bytes_reg[2][0];
                    held_right_speed_reg <= motor_bytes_reg[3];
                end
                if (light_hit)
                    held_light_reg <= light_value_reg ? LIGHT_ON : LIGHT_OFF;
                held_text_reg   <= text_cmd_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_byte_reg <= rx_byte;
        if (advance)
        begin
            if (motor_write)
                motor_bytes_reg[motor_idx] <= b;
            taken_by_reg     <= taken_by_next;
            motor_update_reg <= motor_hit;
            light_update_reg <= light_hit;
            text_update_reg  <= text_hit;
        end
    end

    // held commands change only when a result loads, so they drive the ports directly
    assign out_valid       = out_valid_reg;
    assign taken_by        = taken_by_reg;
    assign motor_update    = motor_update_reg;
    assign left_direction  = held_left_dir_reg;
    assign left_speed      = held_left_speed_reg;
    assign right_direction = held_right_dir_reg;
    assign right_speed     = held_right_speed_reg;
    assign light_update    = light_update_reg;
    assign light_command   = held_light_reg;
    assign text_update     = text_update_reg;
    assign text_command    = held_text_reg;

endmodule

/* hw/rtl/ucfp_checker.sv */
module ucfp_checker
    import ucfp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] taken_by,
    input logic       motor_update,
    input logic       left_direction,
    input logic [7:0] left_speed,
    input logic       right_direction,
    input logic [7:0] right_speed,
    input logic       light_update,
    input logic [1:0] light_command,
    input logic       text_update,
    input logic [1:0] text_command
);

    // an update pulse always belongs to the parser that took the beat
    a_update_owner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!motor_update || taken_by == TAKEN_MOTOR)
                   && (!light_update || taken_by == TAKEN_LIGHT)
                   && (!text_update  || taken_by == TAKEN_TEXT))
        else $error("update pulse from a parser that did not take the beat");

    // held motor command moves only with a completed motor frame
    a_motor_held: assert property (@(posedge clk) disable iff (!rst_n)
        !($stable(left_speed) && $stable(right_speed)
          && $stable(left_direction) && $stable(right_direction))
        |-> out_valid && motor_update)
        else $error("held motor command changed without a motor update");

    // held light command moves only with a completed light frame
    a_light_held: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(light_command) |-> out_valid && light_update)
        else $error("held light command changed without a light update");

    // held text command moves only with a recognized word
    a_text_held: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(text_command) |-> out_valid && text_update)
        else $error("held text command changed without a text update");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(taken_by))
        else $error("result beat dropped or changed while stalled");

endmodule

bind uart_command_frame_parser ucfp_checker u_ucfp_checker (.*);

/* tb/tb_uart_command_frame_parser.sv */
module tb_uart_command_frame_parser
    import ucfp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          STALL_CYCLES = 80;
    localparam logic [39:0] WORD_HELLO   = "HELLO";
    localparam logic [39:0] WORD_STOP    = "STOP!";

    typedef struct packed {
        logic [1:0] taken_by;
        logic       motor_update;
        logic       left_direction;
        logic [7:0] left_speed;
        logic       right_direction;
        logic [7:0] right_speed;
        logic       light_update;
        logic [1:0] light_command;
        logic       text_update;
        logic [1:0] text_command;
    } parse_result_t;

    class command_scoreboard;
        logic [7:0]    speed_limit;
        logic [2:0]    motor_pos;
        logic [7:0]    motor_buf [4];
        light_phase_t  light_phase;
        logic          light_bit;
        logic [2:0]    text_pos;
        logic [7:0]    text_buf [5];
        logic [7:0]    held_motor [4];
        logic [1:0]    held_light;
        logic [1:0]    held_text;
        parse_result_t pending_results [$];
        int            result_count;
        int            mismatches;

        function new();
            speed_limit = SPEED_LIMIT_RESET;
            motor_pos = '0;
            light_phase = LIGHT_IDLE;
            light_bit = 1'b0;
            text_pos = '0;
            held_light = LIGHT_NONE;
            held_text = TEXT_NONE;
            foreach (motor_buf[i]) motor_buf[i] = '0;
            foreach (held_motor[i]) held_motor[i] = '0;
            foreach (text_buf[i]) text_buf[i] = '0;
            result_count = 0;
            mismatches = 0;
        endfunction

        function bit take_motor(logic [7:0] b, output bit done);
            done = 1'b0;
            if (b == MOTOR_START)
            begin
                motor_pos = 3'd1;
                return 1'b1;
            end
            if (motor_pos == 3'd0)
                return 1'b0;
            if (motor_pos < MOTOR_LAST_POS)
            begin
                motor_buf[2'(motor_pos - 3'd1)] = b;
                motor_pos++;
                return 1'b1;
            end
            // sixth byte closes the frame, valid or not
            motor_pos = 3'd0;
            if (b == MOTOR_END && motor_buf[0] <= 8'd1 && motor_buf[1] <= speed_limit &&
                motor_buf[2] <= 8'd1 && motor_buf[3] <= speed_limit)
            begin
                held_motor = motor_buf;
                done = 1'b1;
            end
            return 1'b1;
        endfunction

        function bit take_light(logic [7:0] b, output bit done);
            done = 1'b0;
            case (light_phase)
                LIGHT_IDLE:
                begin
                    if (b != LIGHT_START)
                        return 1'b0;
                    light_phase = LIGHT_GOT_START;
                end
                LIGHT_GOT_START:
                begin
                    if (b == LIGHT_TAG)
                        light_phase = LIGHT_GOT_TAG;
                    else if (b == LIGHT_START)
                        light_phase = LIGHT_GOT_START;
                    else
                        light_phase = LIGHT_IDLE;
                end
                LIGHT_GOT_TAG:
                begin
                    if (b <= 8'd1)
                    begin
                        light_bit = b[0];
                        light_phase = LIGHT_GOT_STATE;
                    end
                    else if (b == LIGHT_START)
                        light_phase = LIGHT_GOT_START;
                    else
                        light_phase = LIGHT_IDLE;
                end
                LIGHT_GOT_STATE:
                begin
                    if (b == (LIGHT_TAG ^ {7'd0, light_bit}))
                        light_phase = LIGHT_GOT_CHECK;
                    else
                        light_phase = LIGHT_IDLE;
                end
                LIGHT_GOT_CHECK:
                begin
                    if (b == LIGHT_END)
                    begin
                        held_light = light_bit ? LIGHT_ON : LIGHT_OFF;
                        done = 1'b1;
                    end
                    light_phase = LIGHT_IDLE;
                end
                default:
                begin
                    light_phase = LIGHT_IDLE;
                    return 1'b0;
                end
            endcase
            return 1'b1;
        endfunction

        function void take_text(logic [7:0] b, output bit done);
            logic [39:0] word;
            done = 1'b0;
            if (b == CHAR_CR || b == CHAR_LF)
            begin
                text_pos = 3'd0;
                return;
            end
            if (text_pos > TEXT_LAST_POS)
                text_pos = 3'd0;
            text_buf[text_pos] = b;
            text_pos++;
            if (text_pos == TEXT_LAST_POS + 3'd1)
            begin
                word = {text_buf[0], text_buf[1], text_buf[2], text_buf[3], text_buf[4]};
                if (word == WORD_HELLO)
                begin
                    held_text = TEXT_HELLO;
                    done = 1'b1;
                end
                else if (word == WORD_STOP)
                begin
                    held_text = TEXT_STOP;
                    done = 1'b1;
                end
                text_pos = 3'd0;
            end
        endfunction

        function void predict_byte(logic [7:0] b);
            parse_result_t r;
            bit            motor_done;
            bit            light_done;
            bit            text_done;
            r = '0;
            light_done = 1'b0;
            text_done = 1'b0;
            if (take_motor(b, motor_done))
                r.taken_by = TAKEN_MOTOR;
            else if (take_light(b, light_done))
                r.taken_by = TAKEN_LIGHT;
            else
            begin
                take_text(b, text_done);
                r.taken_by = TAKEN_TEXT;
            end
            r.motor_update = motor_done;
            r.left_direction = held_motor[0][0];
            r.left_speed = held_motor[1];
            r.right_direction = held_motor[2][0];
            r.right_speed = held_motor[3];
            r.light_update = light_done;
            r.light_command = held_light;
            r.text_update = text_done;
            r.text_command = held_text;
            pending_results.push_back(r);
        endfunction

        task report(string what, int got_value, int want_value);
            mismatches++;
            $display("mismatch at result %0d: %s got %0h want %0h",
                     result_count, what, got_value, want_value);
        endtask

        task check_result(parse_result_t got);
            parse_result_t want;
            result_count++;
            if (pending_results.size() == 0)
            begin
                report("result with nothing pending, taken_by", int'(got.taken_by), 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.taken_by !== want.taken_by)
                report("taken_by", int'(got.taken_by), int'(want.taken_by));
            if (got.motor_update !== want.motor_update)
                report("motor_update", int'(got.motor_update), int'(want.motor_update));
            if (got.left_direction !== want.left_direction)
                report("left_direction", int'(got.left_direction),
                       int'(want.left_direction));
            if (got.left_speed !== want.left_speed)
                report("left_speed", int'(got.left_speed), int'(want.left_speed));
            if (got.right_direction !== want.right_direction)
                report("right_direction", int'(got.right_direction),
                       int'(want.right_direction));
            if (got.right_speed !== want.right_speed)
                report("right_speed", int'(got.right_speed), int'(want.right_speed));
            if (got.light_update !== want.light_update)
                report("light_update", int'(got.light_update), int'(want.light_update));
            if (got.light_command !== want.light_command)
                report("light_command", int'(got.light_command), int'(want.light_command));
            if (got.text_update !== want.text_update)
                report("text_update", int'(got.text_update), int'(want.text_update));
            if (got.text_command !== want.text_command)
                report("text_command", int'(got.text_command), int'(want.text_command));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] taken_by;
    logic       motor_update;
    logic       left_direction;
    logic [7:0] left_speed;
    logic       right_direction;
    logic [7:0] right_speed;
    logic       light_update;
    logic [1:0] light_command;
    logic       text_update;
    logic [1:0] text_command;

    command_scoreboard scoreboard;
    int         send_idle_pct = 9;
    int         recv_idle_pct = 56;
    int         hold_requests = 0;
    int         bytes_sent = 0;
    int         cycle_count = 0;
    logic [7:0] cur_limit = SPEED_LIMIT_RESET;

    uart_command_frame_parser u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .taken_by        (taken_by),
        .motor_update    (motor_update),
        .left_direction  (left_direction),
        .left_speed      (left_speed),
        .right_direction (right_direction),
        .right_speed     (right_speed),
        .light_update    (light_update),
        .light_command   (light_command),
        .text_update     (text_update),
        .text_command    (text_command)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("uart_command_frame_parser test failed");
            $finish;
        end
    end

    // result side: check each beat, then decide next ready
    initial
    begin
        int            hold_left;
        int            hold_seen;
        parse_result_t got;
        hold_left = 0;
        hold_seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {taken_by, motor_update, left_direction, left_speed, right_direction,
                       right_speed, light_update, light_command, text_update, text_command};
                scoreboard.check_result(got);
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scoreboard.predict_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (scoreboard.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_speed_limit(input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        scoreboard.speed_limit = value;
        cur_limit = value;
    endtask

    function automatic logic [7:0] pick_direction();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(0, 1));
        return 8'($urandom_range(2, 255));
    endfunction

    // speeds cluster around the limit so both sides of the compare get hit
    function automatic logic [7:0] pick_speed();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 8'($urandom_range(0, cur_limit));
        if (roll < 60)
            return cur_limit;
        if (roll < 75)
            return cur_limit + 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_motor_frame();
        int cut;
        send_byte(MOTOR_START);
        // a short frame leaves the parser mid-frame for whatever follows
        cut = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 3) : 4;
        for (int i = 0; i < cut; i++)
            send_byte((i % 2 == 0) ? pick_direction() : pick_speed());
        if (cut == 4)
            send_byte(($urandom_range(0, 99) < 90) ? MOTOR_END : 8'($urandom_range(0, 255)));
    endtask

    task automatic send_light_frame();
        logic [7:0] state_byte;
        send_byte(LIGHT_START);
        if ($urandom_range(0, 99) < 8)
            send_byte(LIGHT_START);
        send_byte(($urandom_range(0, 99) < 90) ? LIGHT_TAG : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 85)
            state_byte = 8'($urandom_range(0, 1));
        else if ($urandom_range(0, 1) == 0)
            state_byte = LIGHT_START;
        else
            state_byte = 8'($urandom_range(0, 255));
        send_byte(state_byte);
        send_byte(($urandom_range(0, 99) < 85) ? (LIGHT_TAG ^ state_byte)
                                               : 8'($urandom_range(0, 255)));
        send_byte(($urandom_range(0, 99) < 85) ? LIGHT_END : 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text_word();
        logic [39:0] word;
        if ($urandom_range(0, 99) < 60)
            send_byte(($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF);
        word = ($urandom_range(0, 1) == 0) ? WORD_HELLO : WORD_STOP;
        if ($urandom_range(0, 99) < 20)
            word[8 * $urandom_range(0, 4) +: 8] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 5; i++)
            send_byte(word[8 * (4 - i) +: 8]);
    endtask

    task automatic send_noise();
        int count;
        count = $urandom_range(1, 4);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 70)
                send_byte(8'($urandom_range(0, 255)));
            else
                case ($urandom_range(0, 8))
                    0: send_byte(MOTOR_START);
                    1: send_byte(MOTOR_END);
                    2: send_byte(LIGHT_START);
                    3: send_byte(LIGHT_TAG);
                    4: send_byte(LIGHT_END);
                    5: send_byte(CHAR_CR);
                    6: send_byte(CHAR_LF);
                    7: send_byte(8'h00);
                    default: send_byte(8'h01);
                endcase
        end
    endtask

    task automatic send_random_sequence();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            send_motor_frame();
        else if (roll < 55)
            send_light_frame();
        else if (roll < 80)
            send_text_word();
        else
            send_noise();
    endtask

    initial
    begin
        logic [7:0] directed_q [$];
        logic [7:0] limits [6];
        int         target;
        scoreboard = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // over-limit frame with 0xff speed, then a frame right at the reset limit,
        // a light-on frame and STOP! after a line break
        directed_q = '{MOTOR_START, 8'h01, 8'hFF, 8'h01, 8'h00, MOTOR_END,
                       MOTOR_START, 8'h00, SPEED_LIMIT_RESET, 8'h01, 8'h00, MOTOR_END,
                       LIGHT_START, LIGHT_TAG, 8'h01, LIGHT_TAG ^ 8'h01, LIGHT_END,
                       CHAR_LF, "S", "T", "O", "P", "!"};
        foreach (directed_q[i])
            send_byte(directed_q[i]);
        wait_drained();

        limits[0] = 8'd0;
        limits[1] = 8'd255;
        limits[2] = 8'($urandom_range(1, 254));
        limits[3] = SPEED_LIMIT_RESET;
        limits[4] = 8'($urandom_range(0, 255));
        limits[5] = 8'd255;
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 56;
            end
            else if (p < 4)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_speed_limit(limits[p]);
            target = bytes_sent + 100;
            while (bytes_sent < target)
                send_random_sequence();
            // long output stall while bytes keep coming, so the input backs up
            if (p == 1 || p == 4)
                hold_requests++;
            target = bytes_sent + 200;
            while (bytes_sent < target)
                send_random_sequence();
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (scoreboard.mismatches == 0 && scoreboard.pending_results.size() == 0)
            $display("uart_command_frame_parser test passed");
        else
            $display("uart_command_frame_parser test failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ucfp_pkg.sv
hw/rtl/uart_command_frame_parser.sv
hw/rtl/ucfp_checker.sv
tb/tb_uart_command_frame_parser.sv
